### sv/owbm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package owbm_pkg;

  localparam int TIMER_W       = 10;
  localparam int CFG_W         = 10;
  localparam int NUM_REGS      = 8;
  localparam int CFG_IDX_W     = $clog2(NUM_REGS);
  localparam int BITS_PER_BYTE = 8;
  localparam int BIT_CNT_W     = $clog2(BITS_PER_BYTE);
  localparam int READ_LOW_US   = 2;
  localparam int Q_DEPTH       = 2;

  // register indexes on the write port
  localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRES_SAMPLE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRES_END      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WR_ONE_LOW    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WR_ZERO_LOW   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WR_SLOT       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RD_SAMPLE     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RD_TAIL       = 3'd7;

  typedef enum logic [2:0] {
    FN_RESET   = 3'd0,
    FN_WR_BIT  = 3'd1,
    FN_WR_BYTE = 3'd2,
    FN_RD_BIT  = 3'd3,
    FN_RD_BYTE = 3'd4
  } func_t;

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_RST_LOW  = 4'd1,
    PH_RST_WAIT = 4'd2,
    PH_RST_END  = 4'd3,
    PH_WR_LOW   = 4'd4,
    PH_WR_REC   = 4'd5,
    PH_RD_LOW   = 4'd6,
    PH_RD_WAIT  = 4'd7,
    PH_RD_TAIL  = 4'd8
  } phase_t;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_PRES  = 2'd1;
  localparam logic [1:0] ST_STUCK    = 2'd2;

  typedef struct packed {
    logic       start_req;
    logic [2:0] func;
    logic [7:0] tx_data;
    logic       line_high;
  } item_t;

  typedef struct packed {
    logic       pull_low;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
    logic [7:0] rx_data;
  } res_t;

  // classified tick as it travels from front to back
  typedef struct packed {
    logic       start;
    func_t      func;
    logic [7:0] data;
    logic       line;
  } cmd_t;

  typedef struct packed {
    logic [CFG_W-1:0] reset_low_time;
    logic [CFG_W-1:0] presence_sample_time;
    logic [CFG_W-1:0] presence_end_time;
    logic [CFG_W-1:0] write_one_low_time;
    logic [CFG_W-1:0] write_zero_low_time;
    logic [CFG_W-1:0] write_slot_time;
    logic [CFG_W-1:0] read_sample_time;
    logic [CFG_W-1:0] read_tail_time;
  } cfg_t;

  localparam cfg_t CFG_DEFAULT = '{
    reset_low_time:       10'd480,
    presence_sample_time: 10'd66,
    presence_end_time:    10'd420,
    write_one_low_time:   10'd10,
    write_zero_low_time:  10'd60,
    write_slot_time:      10'd64,
    read_sample_time:     10'd10,
    read_tail_time:       10'd54
  };

endpackage

`default_nettype wire

### sv/one_wire_bus_master.sv
`timescale 1ns / 1ps
`default_nettype none

// Timed 1-Wire bus master. Every beat pushed in is one microsecond tick that carries an
// optional command request (reset with presence detect, write bit, write byte, read bit,
// read byte) and the sampled line level; every tick yields exactly one result beat with
// the pull-low drive, busy, done, the held reset status and the read data, in order.
// Requests while a command runs and function codes above read byte are ignored. Bytes go
// least significant bit first. The block takes one tick per clock cycle when the result
// side keeps up: a front decoder feeds a two-entry command queue, the timing engine does
// one tick per cycle, and a two-entry result queue decouples the pop side, so a result
// passes through the command queue and the result queue before it is on the result ports.
// The user must write timing registers through the plain write port only while the block
// is idle; the block itself does not enforce this. New values take effect on the next tick.

module one_wire_bus_master #(
  parameter int READ_LOW_US = owbm_pkg::READ_LOW_US
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               push,
  input  wire owbm_pkg::item_t                    item,
  output logic                                    full,
  output logic                                    empty,
  input  wire logic                               pop,
  output owbm_pkg::res_t                          result,
  input  wire logic                               cfg_we,
  input  wire logic [owbm_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  wire logic [owbm_pkg::CFG_W-1:0]         cfg_data
);
  import owbm_pkg::*;

  cfg_t cfg;

  // front side: classified tick
  cmd_t                cmd_w;
  logic [$bits(cmd_t)-1:0] cmd_rdata;
  cmd_t                cmd_r;
  logic                cmd_empty;
  logic                cmd_pop;

  // back side: result beat from the engine
  res_t                res_w;
  logic [$bits(res_t)-1:0] res_rdata;
  logic                res_full;
  logic                res_push;

  // timing registers, one per index
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_DEFAULT;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_RESET_LOW:   cfg.reset_low_time       <= cfg_data;
        REG_PRES_SAMPLE: cfg.presence_sample_time <= cfg_data;
        REG_PRES_END:    cfg.presence_end_time    <= cfg_data;
        REG_WR_ONE_LOW:  cfg.write_one_low_time   <= cfg_data;
        REG_WR_ZERO_LOW: cfg.write_zero_low_time  <= cfg_data;
        REG_WR_SLOT:     cfg.write_slot_time      <= cfg_data;
        REG_RD_SAMPLE:   cfg.read_sample_time     <= cfg_data;
        REG_RD_TAIL:     cfg.read_tail_time       <= cfg_data;
        default:         cfg                      <= cfg;
      endcase
    end
  end

  // decode the request before it is queued
  owbm_front u_front (
    .item (item),
    .cmd  (cmd_w)
  );

  // command queue between front and engine; full here is the input back-pressure
  owbm_fifo #(
    .W     ($bits(cmd_t)),
    .DEPTH (Q_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (cmd_w),
    .full  (full),
    .pop   (cmd_pop),
    .rdata (cmd_rdata),
    .empty (cmd_empty)
  );

  assign cmd_r = cmd_t'(cmd_rdata);

  // timing engine: one tick per cycle whenever a tick waits and the result queue has room
  owbm_engine #(
    .READ_LOW_US (READ_LOW_US)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (!cmd_empty),
    .cmd       (cmd_r),
    .cmd_pop   (cmd_pop),
    .res_ready (!res_full),
    .res_push  (res_push),
    .res       (res_w)
  );

  // result queue toward the consumer
  owbm_fifo #(
    .W     ($bits(res_t)),
    .DEPTH (Q_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_w),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_rdata),
    .empty (empty)
  );

  assign result = res_t'(res_rdata);

  // a command can only complete while it is running
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    (res_push && res_w.done_res) |-> res_w.busy_res)
    else $error("done without busy");

  // the line is only driven during a command
  a_pull_busy: assert property (@(posedge clk) disable iff (rst)
    (res_push && res_w.pull_low) |-> res_w.busy_res)
    else $error("pull low while idle");

  // read data shows only on the done tick
  a_rx_done: assert property (@(posedge clk) disable iff (rst)
    (res_push && (res_w.rx_data != '0)) |-> res_w.done_res)
    else $error("read data outside done tick");

  // engine never takes a tick that the result queue cannot hold
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    res_push |-> (!res_full && !cmd_empty))
    else $error("engine step without room");

endmodule

`default_nettype wire

### sv/owbm_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module owbm_fifo #(
  parameter int W     = 1,
  parameter int DEPTH = 2
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         push,
  input  wire logic [W-1:0] wdata,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      rdata,
  output logic              empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem [DEPTH];
  logic [PW-1:0] wp;
  logic [PW-1:0] rp;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wp <= (wp == PW'(DEPTH - 1)) ? '0 : wp + PW'(1);
      end
      if (do_pop) begin
        rp <= (rp == PW'(DEPTH - 1)) ? '0 : rp + PW'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp] <= wdata;
    end
  end

endmodule

`default_nettype wire

### sv/owbm_front.sv
`timescale 1ns / 1ps
`default_nettype none

module owbm_front (
  input  wire owbm_pkg::item_t item,
  output owbm_pkg::cmd_t       cmd
);
  import owbm_pkg::*;

  // only function codes in range start a command
  always_comb begin
    cmd.start = item.start_req && (item.func inside {[FN_RESET:FN_RD_BYTE]});
    cmd.func  = func_t'(item.func);
    cmd.line  = item.line_high;
    case (item.func)
      FN_WR_BIT:  cmd.data = {7'b0, item.tx_data[0]};
      FN_WR_BYTE: cmd.data = item.tx_data;
      default:    cmd.data = '0;
    endcase
  end

endmodule

`default_nettype wire

### sv/owbm_engine.sv
`timescale 1ns / 1ps
`default_nettype none

module owbm_engine #(
  parameter int READ_LOW_US = owbm_pkg::READ_LOW_US
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire owbm_pkg::cfg_t cfg,
  input  wire logic           cmd_valid,
  input  wire owbm_pkg::cmd_t cmd,
  output logic                cmd_pop,
  input  wire logic           res_ready,
  output logic                res_push,
  output owbm_pkg::res_t      res
);
  import owbm_pkg::*;

  localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

  phase_t               phase, phase_next;
  logic [TIMER_W-1:0]   timer, timer_next;
  logic [BIT_CNT_W-1:0] bit_count, bit_count_next;
  logic [7:0]           shift_data, shift_data_next;
  func_t                active_func, active_func_next;
  logic [1:0]           last_status, last_status_next;

  logic   take;
  logic   start_take;
  phase_t start_phase;
  phase_t ph_run;
  logic   fin;

  assign take     = cmd_valid && res_ready;
  assign cmd_pop  = take;
  assign res_push = take;

  always_comb begin
    case (cmd.func)
      FN_RESET:              start_phase = PH_RST_LOW;
      FN_WR_BIT, FN_WR_BYTE: start_phase = PH_WR_LOW;
      default:               start_phase = PH_RD_LOW;
    endcase
  end

  assign start_take = (phase == PH_IDLE) && cmd.start;
  assign ph_run     = start_take ? start_phase : phase;

  // next state
  always_comb begin
    logic [TIMER_W-1:0] t;
    logic [TIMER_W-1:0] low_len;
    logic [TIMER_W-1:0] rec_len;
    logic               end_bit;
    logic               is_write;
    logic               is_byte;

    phase_next       = ph_run;
    t                = start_take ? '0 : timer;
    bit_count_next   = start_take ? '0 : bit_count;
    shift_data_next  = start_take ? cmd.data : shift_data;
    active_func_next = start_take ? cmd.func : active_func;
    last_status_next = last_status;
    fin              = 1'b0;
    end_bit          = 1'b0;

    low_len = shift_data_next[0] ? cfg.write_one_low_time : cfg.write_zero_low_time;
    rec_len = (cfg.write_slot_time > low_len) ? cfg.write_slot_time - low_len
                                              : TIMER_W'(1);
    is_write = (active_func_next == FN_WR_BIT) || (active_func_next == FN_WR_BYTE);
    is_byte  = (active_func_next == FN_WR_BYTE) || (active_func_next == FN_RD_BYTE);

    if (ph_run != PH_IDLE) begin
      t = (t == TIMER_MAX) ? t : t + TIMER_W'(1);
      case (ph_run)
        PH_RST_LOW: begin
          if (t >= cfg.reset_low_time) begin
            phase_next = PH_RST_WAIT;
            t          = '0;
          end
        end
        PH_RST_WAIT: begin
          if (t >= cfg.presence_sample_time) begin
            if (cmd.line) begin
              last_status_next = ST_NO_PRES;
              fin              = 1'b1;
            end else begin
              phase_next = PH_RST_END;
              t          = '0;
            end
          end
        end
        PH_RST_END: begin
          if (t >= cfg.presence_end_time) begin
            last_status_next = cmd.line ? ST_OK : ST_STUCK;
            fin              = 1'b1;
          end
        end
        PH_WR_LOW: begin
          if (t >= low_len) begin
            phase_next = PH_WR_REC;
            t          = '0;
          end
        end
        PH_WR_REC: begin
          if (t >= rec_len) begin
            end_bit = 1'b1;
          end
        end
        PH_RD_LOW: begin
          if (t >= TIMER_W'(READ_LOW_US)) begin
            phase_next = PH_RD_WAIT;
            t          = '0;
          end
        end
        PH_RD_WAIT: begin
          if (t >= cfg.read_sample_time) begin
            shift_data_next = {cmd.line, shift_data_next[7:1]};
            if (cfg.read_tail_time == '0) begin
              end_bit = 1'b1;
            end else begin
              phase_next = PH_RD_TAIL;
              t          = '0;
            end
          end
        end
        PH_RD_TAIL: begin
          if (t >= cfg.read_tail_time) begin
            end_bit = 1'b1;
          end
        end
        default: fin = 1'b1;
      endcase
    end

    if (end_bit) begin
      if (is_write) begin
        shift_data_next = {1'b0, shift_data_next[7:1]};
      end
      if (is_byte && (bit_count_next < BIT_CNT_W'(BITS_PER_BYTE - 1))) begin
        bit_count_next = bit_count_next + BIT_CNT_W'(1);
        phase_next     = is_write ? PH_WR_LOW : PH_RD_LOW;
        t              = '0;
      end else begin
        fin = 1'b1;
      end
    end

    if (fin) begin
      phase_next = PH_IDLE;
      t          = '0;
    end
    timer_next = t;
  end

  // outputs
  always_comb begin
    res.pull_low = (ph_run == PH_RST_LOW) || (ph_run == PH_WR_LOW) ||
                   (ph_run == PH_RD_LOW);
    res.busy_res = (ph_run != PH_IDLE);
    res.done_res = fin;
    res.status   = last_status_next;
    res.rx_data  = '0;
    if (fin) begin
      case (active_func_next)
        FN_RD_BIT:  res.rx_data = {7'b0, shift_data_next[7]};
        FN_RD_BYTE: res.rx_data = shift_data_next;
        default:    res.rx_data = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      timer       <= '0;
      bit_count   <= '0;
      shift_data  <= '0;
      active_func <= FN_RESET;
      last_status <= ST_OK;
    end else if (take) begin
      phase       <= phase_next;
      timer       <= timer_next;
      bit_count   <= bit_count_next;
      shift_data  <= shift_data_next;
      active_func <= active_func_next;
      last_status <= last_status_next;
    end
  end

endmodule

`default_nettype wire

### bench/tb.sv
`timescale 1ns / 1ps

module tb;
  import owbm_pkg::*;

  // ticks with neither side moving before the run is called hung
  localparam int STALL_LIMIT  = 2000;
  // random part: three timing settings, each held for at least this many ticks
  localparam int PHASE_TICKS  = 30;
  localparam int RANDOM_PHASES = 3;

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic                 push     = 1'b0;
  item_t                item     = '0;
  logic                 pop      = 1'b0;
  logic                 cfg_we   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx  = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 full;
  logic                 empty;
  res_t                 result;

  one_wire_bus_master dut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .item     (item),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .result   (result),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // bus master shadow: timing registers and sequencer state
  cfg_t        timing;
  phase_t      ph;
  logic [9:0]  tmr;
  logic [2:0]  bitn;
  logic [7:0]  shreg;
  logic [2:0]  cur_func;
  logic [1:0]  rst_status;
  bit          fin;

  res_t        expected_ticks[$];
  int          mismatches  = 0;
  int          ticks_sent  = 0;
  int          quiet_cycles = 0;
  int          pop_hold    = 0;

  // stimulus knobs
  bit          idle_on = 1'b1;  // random gaps on both sides
  bit          chatter = 1'b0;  // stray requests while a command runs
  bit          noisy   = 1'b0;  // line level random instead of well-formed
  bit          want_presence;
  bit          want_stuck;
  logic [7:0]  rd_bits;

  // ---------------------------------------------------------------------------
  // shadow sequencer
  // ---------------------------------------------------------------------------

  task automatic shadow_finish();
    fin = 1'b1;
    ph  = PH_IDLE;
    tmr = '0;
  endtask

  function automatic logic [9:0] wr_low_len();
    return shreg[0] ? timing.write_one_low_time : timing.write_zero_low_time;
  endfunction

  // close one bit slot: shift out a written bit, then next slot or done
  task automatic shadow_end_bit();
    bit is_write;
    bit is_byte;
    is_write = (cur_func == FN_WR_BIT) || (cur_func == FN_WR_BYTE);
    is_byte  = (cur_func == FN_WR_BYTE) || (cur_func == FN_RD_BYTE);
    if (is_write) shreg = shreg >> 1;
    if (is_byte && bitn < BITS_PER_BYTE - 1) begin
      bitn = bitn + 3'd1;
      ph   = is_write ? PH_WR_LOW : PH_RD_LOW;
      tmr  = '0;
    end else begin
      shadow_finish();
    end
  endtask

  // one microsecond tick in, one result beat out
  task automatic bus_tick(input item_t it, output res_t r);
    logic       pull;
    logic       busy;
    logic [7:0] rx;
    logic [9:0] low;
    logic [9:0] rec;
    fin  = 1'b0;
    pull = 1'b0;
    busy = 1'b0;
    rx   = '0;
    // a request is taken only when idle and only for a known function
    if (ph == PH_IDLE && it.start_req && it.func <= FN_RD_BYTE) begin
      cur_func = it.func;
      bitn     = '0;
      tmr      = '0;
      if (it.func == FN_RESET) begin
        shreg = '0;
        ph    = PH_RST_LOW;
      end else if (it.func == FN_WR_BIT || it.func == FN_WR_BYTE) begin
        shreg = (it.func == FN_WR_BYTE) ? it.tx_data : {7'b0, it.tx_data[0]};
        ph    = PH_WR_LOW;
      end else begin
        shreg = '0;
        ph    = PH_RD_LOW;
      end
    end
    if (ph != PH_IDLE) begin
      busy = 1'b1;
      if (tmr != 10'd1023) tmr = tmr + 10'd1;
      case (ph)
        PH_RST_LOW: begin
          pull = 1'b1;
          if (tmr >= timing.reset_low_time) begin
            ph  = PH_RST_WAIT;
            tmr = '0;
          end
        end
        PH_RST_WAIT: begin
          if (tmr >= timing.presence_sample_time) begin
            if (it.line_high) begin
              rst_status = ST_NO_PRES;
              shadow_finish();
            end else begin
              ph  = PH_RST_END;
              tmr = '0;
            end
          end
        end
        PH_RST_END: begin
          if (tmr >= timing.presence_end_time) begin
            rst_status = it.line_high ? ST_OK : ST_STUCK;
            shadow_finish();
          end
        end
        PH_WR_LOW: begin
          pull = 1'b1;
          if (tmr >= wr_low_len()) begin
            ph  = PH_WR_REC;
            tmr = '0;
          end
        end
        PH_WR_REC: begin
          low = wr_low_len();
          rec = (timing.write_slot_time > low) ? timing.write_slot_time - low : 10'd1;
          if (tmr >= rec) shadow_end_bit();
        end
        PH_RD_LOW: begin
          pull = 1'b1;
          if (tmr >= READ_LOW_US) begin
            ph  = PH_RD_WAIT;
            tmr = '0;
          end
        end
        PH_RD_WAIT: begin
          if (tmr >= timing.read_sample_time) begin
            shreg = {it.line_high, shreg[7:1]};
            if (timing.read_tail_time == '0) begin
              shadow_end_bit();
            end else begin
              ph  = PH_RD_TAIL;
              tmr = '0;
            end
          end
        end
        PH_RD_TAIL: begin
          if (tmr >= timing.read_tail_time) shadow_end_bit();
        end
        default: shadow_finish();
      endcase
      if (fin) begin
        if (cur_func == FN_RD_BIT) rx = {7'b0, shreg[7]};
        else if (cur_func == FN_RD_BYTE) rx = shreg;
      end
    end
    r.pull_low = pull;
    r.busy_res = busy;
    r.done_res = fin;
    r.status   = rst_status;
    r.rx_data  = rx;
  endtask

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------

  // push one tick beat, with an occasional gap in front of it
  task automatic send_tick(input item_t it);
    res_t r;
    if (idle_on && $urandom_range(0, 9) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    push <= 1'b1;
    item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
    bus_tick(it, r);
    expected_ticks.push_back(r);
    ticks_sent++;
  endtask

  // line level a well-behaved slave would show on the coming tick
  function automatic logic next_line();
    if (noisy) return 1'($urandom_range(0, 1));
    case (ph)
      PH_RST_WAIT: return !want_presence;
      PH_RST_END:  return !want_stuck;
      PH_RD_WAIT:  return rd_bits[bitn];
      default:     return 1'($urandom_range(0, 1));
    endcase
  endfunction

  // issue one command and keep ticking until the shadow goes idle again
  task automatic run_cmd(input logic [2:0] fn, input logic [7:0] tx, input bit presence,
                         input bit stuck, input logic [7:0] slave_byte);
    item_t it;
    want_presence = presence;
    want_stuck    = stuck;
    rd_bits       = slave_byte;
    it.start_req  = 1'b1;
    it.func       = fn;
    it.tx_data    = tx;
    it.line_high  = 1'($urandom_range(0, 1));
    send_tick(it);
    while (ph != PH_IDLE) begin
      // stray requests while busy must be dropped, done tick included
      it.start_req = chatter && ($urandom_range(0, 3) == 0);
      it.func      = 3'($urandom_range(0, 7));
      it.tx_data   = 8'($urandom);
      it.line_high = next_line();
      send_tick(it);
    end
  endtask

  // stop pushing and let every outstanding beat come back
  task automatic drain();
    push <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  // new timing only with the block fully idle
  task automatic retime(input cfg_t c);
    drain();
    write_reg(REG_RESET_LOW,   c.reset_low_time);
    write_reg(REG_PRES_SAMPLE, c.presence_sample_time);
    write_reg(REG_PRES_END,    c.presence_end_time);
    write_reg(REG_WR_ONE_LOW,  c.write_one_low_time);
    write_reg(REG_WR_ZERO_LOW, c.write_zero_low_time);
    write_reg(REG_WR_SLOT,     c.write_slot_time);
    write_reg(REG_RD_SAMPLE,   c.read_sample_time);
    write_reg(REG_RD_TAIL,     c.read_tail_time);
    cfg_we <= 1'b0;
    timing = c;
  endtask

  function automatic cfg_t all_timing(input logic [9:0] v);
    cfg_t c;
    c = '{v, v, v, v, v, v, v, v};
    return c;
  endfunction

  // mostly a few microseconds, now and then zero or a longer stretch
  function automatic logic [9:0] rand_dur();
    int k;
    k = $urandom_range(0, 19);
    if (k == 0) return '0;
    if (k == 1) return 10'($urandom_range(7, 40));
    return 10'($urandom_range(1, 6));
  endfunction

  function automatic cfg_t rand_timing();
    cfg_t c;
    c.reset_low_time       = rand_dur();
    c.presence_sample_time = rand_dur();
    c.presence_end_time    = rand_dur();
    c.write_one_low_time   = rand_dur();
    c.write_zero_low_time  = rand_dur();
    c.write_slot_time      = rand_dur();
    c.read_sample_time     = rand_dur();
    c.read_tail_time       = ($urandom_range(0, 3) == 0) ? 10'd0 : rand_dur();
    return c;
  endfunction

  // result side: pop with random stall bursts
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (pop_hold > 0) begin
      pop_hold = pop_hold - 1;
      pop <= 1'b0;
    end else if (idle_on && $urandom_range(0, 11) == 0) begin
      pop_hold = $urandom_range(0, 18);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // result checking: every popped beat against the oldest prediction
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : check_beat
    res_t want;
    if (!rst && pop && !empty) begin
      if (expected_ticks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected beat p=%b b=%b d=%b s=%0d rx=%h",
                   $time, result.pull_low, result.busy_res, result.done_res,
                   result.status, result.rx_data);
      end else begin
        want = expected_ticks.pop_front();
        if (result.pull_low !== want.pull_low || result.busy_res !== want.busy_res ||
            result.done_res !== want.done_res || result.status !== want.status ||
            result.rx_data !== want.rx_data) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: exp p=%b b=%b d=%b s=%0d rx=%h got p=%b b=%b d=%b s=%0d rx=%h",
                     $time, want.pull_low, want.busy_res, want.done_res, want.status,
                     want.rx_data, result.pull_low, result.busy_res, result.done_res,
                     result.status, result.rx_data);
        end
      end
    end
  end

  // hang detector: nothing moving on either side for too long
  always @(posedge clk) begin
    if (rst || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("** one_wire_bus_master: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // timing straight out of reset, standard slot lengths
  task automatic test_reset_timing();
    run_cmd(FN_WR_BIT, 8'h01, 1'b1, 1'b0, 8'h00);
    run_cmd(FN_RD_BIT, 8'h00, 1'b1, 1'b0, 8'h01);
  endtask

  // presence found, no presence, line held low past the window
  task automatic test_reset_status();
    retime('{10'd5, 10'd4, 10'd6, 10'd1, 10'd3, 10'd4, 10'd1, 10'd1});
    run_cmd(FN_RESET, 8'h00, 1'b1, 1'b0, 8'h00);
    run_cmd(FN_RESET, 8'h00, 1'b0, 1'b0, 8'h00);
    run_cmd(FN_RESET, 8'h00, 1'b1, 1'b1, 8'h00);
  endtask

  // every write and read flavor, data extremes
  task automatic test_slots();
    run_cmd(FN_WR_BIT, 8'hFE, 1'b1, 1'b0, 8'h00);
    run_cmd(FN_WR_BIT, 8'h01, 1'b1, 1'b0, 8'h00);
    run_cmd(FN_WR_BYTE, 8'h00, 1'b1, 1'b0, 8'h00);
    run_cmd(FN_WR_BYTE, 8'hFF, 1'b1, 1'b0, 8'h00);
    run_cmd(FN_RD_BIT, 8'h00, 1'b1, 1'b0, 8'h00);
    run_cmd(FN_RD_BIT, 8'h00, 1'b1, 1'b0, 8'hFF);
    run_cmd(FN_RD_BYTE, 8'h00, 1'b1, 1'b0, 8'h00);
    run_cmd(FN_RD_BYTE, 8'h00, 1'b1, 1'b0, 8'hFF);
  endtask

  // requests while busy and unknown function codes go nowhere
  task automatic test_ignored();
    chatter = 1'b1;
    run_cmd(FN_WR_BYTE, 8'h96, 1'b1, 1'b0, 8'h00);
    run_cmd(FN_RD_BYTE, 8'h00, 1'b1, 1'b0, 8'h69);
    run_cmd(3'd5, 8'hFF, 1'b1, 1'b0, 8'h00);
    run_cmd(3'd6, 8'h00, 1'b1, 1'b0, 8'h00);
    run_cmd(3'd7, 8'h5A, 1'b1, 1'b0, 8'h00);
    chatter = 1'b0;
  endtask

  // zero durations collapse to one tick; tail of zero ends on the sample
  task automatic test_zero_times();
    retime(all_timing(10'd0));
    run_cmd(FN_RESET, 8'h00, 1'b1, 1'b0, 8'h00);
    run_cmd(FN_WR_BYTE, 8'h5A, 1'b1, 1'b0, 8'h00);
    run_cmd(FN_RD_BYTE, 8'h00, 1'b1, 1'b0, 8'hC3);
    run_cmd(FN_RD_BIT, 8'h00, 1'b1, 1'b0, 8'h01);
    // slot shorter than the low pulse: release is a single tick
    retime('{10'd3, 10'd2, 10'd2, 10'd3, 10'd9, 10'd4, 10'd2, 10'd0});
    run_cmd(FN_WR_BYTE, 8'h0F, 1'b1, 1'b0, 8'h00);
    run_cmd(FN_RD_BYTE, 8'h00, 1'b1, 1'b0, 8'hA5);
  endtask

  // random commands under random timing; last setting runs without gaps
  task automatic test_random();
    int    base;
    item_t gap;
    logic [2:0] fn;
    for (int n = 0; n < RANDOM_PHASES; n++) begin
      retime(rand_timing());
      idle_on = (n != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      chatter = 1'b1;
      base = ticks_sent;
      while (ticks_sent - base < PHASE_TICKS) begin
        fn = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                         : 3'($urandom_range(0, 4));
        noisy = ($urandom_range(0, 7) == 0);
        run_cmd(fn, 8'($urandom), $urandom_range(0, 3) != 0, $urandom_range(0, 3) == 0,
                8'($urandom));
        noisy = 1'b0;
        // a few plain ticks between commands
        repeat ($urandom_range(0, 3)) begin
          gap.start_req = 1'b0;
          gap.func      = 3'($urandom_range(0, 7));
          gap.tx_data   = 8'($urandom);
          gap.line_high = 1'($urandom_range(0, 1));
          send_tick(gap);
        end
      end
    end
  endtask

  initial begin
    timing     = CFG_DEFAULT;
    ph         = PH_IDLE;
    tmr        = '0;
    bitn       = '0;
    shreg      = '0;
    cur_func   = '0;
    rst_status = ST_OK;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_reset_timing();
    test_reset_status();
    test_slots();
    test_ignored();
    test_zero_times();
    test_random();

    // everything back, plus the pipeline depth
    drain();
    if (mismatches == 0 && expected_ticks.size() == 0) begin
      $display("** one_wire_bus_master: PASSED **");
    end else begin
      $display("** one_wire_bus_master: FAILED **");
    end
    $finish;
  end

endmodule
